// ----- src/fmmp_pkg.sv -----
// ----------------------------------------------------------------------------
// Fibonacci modulo matrix power: shared types
// Command and status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package fmmp_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SQUARE,
      ST_MULT,
      ST_FINAL,
      ST_DONE
   } state_type;

   // Datapath operation select.
   typedef enum logic [1:0] {
      OP_SQUARE,
      OP_MULT_BASE,
      OP_SUM_ROW
   } op_type;

   typedef struct packed {
      logic   load;
      logic   start;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } status_type;

endpackage

// ----- src/fmmp_modmul.sv -----
// ----------------------------------------------------------------------------
// Fibonacci modulo matrix power: modular multiply-add unit
// Computes (a*b + c) mod m by shift-and-add, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module fmmp_modmul #(
   parameter int MOD_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [MOD_BITS-1:0] a,
   input  logic [MOD_BITS-1:0] b,
   input  logic [MOD_BITS-1:0] c,
   input  logic [MOD_BITS-1:0] m,
   output logic                done,
   output logic [MOD_BITS-1:0] result
);
   localparam int CW = $clog2(MOD_BITS + 1);

   logic [MOD_BITS-1:0] acc_ff, acc_in;
   logic [MOD_BITS-1:0] mb_ff, mb_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                run_ff, run_in;
   logic                done_ff, done_in;
   logic [MOD_BITS:0]   dbl, dbl_r, add, add_r;

   // Horner step: acc = 2*acc (+ a), each reduced by one compare and subtract.
   always_comb begin
      dbl    = {acc_ff, 1'b0};
      dbl_r  = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
      add    = dbl_r + {1'b0, a};
      add_r  = (add >= {1'b0, m}) ? add - {1'b0, m} : add;
      acc_in  = acc_ff;
      mb_in   = mb_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         // The product starts from zero; c is added once the last bit is in.
         acc_in = '0;
         mb_in  = b;
         cnt_in = CW'(MOD_BITS);
         run_in = 1'b1;
      end else if (run_ff) begin
         acc_in = mb_ff[MOD_BITS-1] ? add_r[MOD_BITS-1:0] : dbl_r[MOD_BITS-1:0];
         mb_in  = {mb_ff[MOD_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      acc_ff <= acc_in;
      mb_ff  <= mb_in;
      cnt_ff <= cnt_in;
   end

   // Final addend, reduced once.
   logic [MOD_BITS:0] fin;
   always_comb begin
      fin = {1'b0, acc_ff} + {1'b0, c};
      if (fin >= {1'b0, m}) fin = fin - {1'b0, m};
   end

   assign done   = done_ff;
   assign result = fin[MOD_BITS-1:0];
endmodule

// ----- src/fmmp_datapath.sv -----
// ----------------------------------------------------------------------------
// Fibonacci modulo matrix power: datapath
// Holds the accumulator matrix and runs the eight modular products of one
// 2x2 matrix product through one shared multiply-add unit.
// ----------------------------------------------------------------------------
module fmmp_datapath #(
   parameter int MOD_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  fmmp_pkg::cmd_type      cmd,
   input  logic [MOD_BITS-1:0]    modulus,
   output fmmp_pkg::status_type   status,
   output logic [MOD_BITS-1:0]    value
);
   logic [MOD_BITS-1:0] mat_ff [4];
   logic [MOD_BITS-1:0] mat_in [4];
   logic [MOD_BITS-1:0] nxt_ff [4];
   logic [MOD_BITS-1:0] m_ff;
   logic [3:0]          step_ff, step_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic                go_ff, go_in;
   fmmp_pkg::op_type    op_ff;
   logic [MOD_BITS-1:0] one_m;
   logic [MOD_BITS-1:0] ma, mbv, mc;
   logic                mm_done;
   logic [MOD_BITS-1:0] mm_res;
   logic                i, j;
   logic                k;

   assign one_m = (modulus == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);

   // Step sequence: entry e = step[2:1], term k = step[0].
   always_comb begin
      i  = step_ff[2];
      j  = step_ff[1];
      k  = step_ff[0];
      ma = mat_ff[{i, k}];
      if (op_ff == fmmp_pkg::OP_SQUARE) mbv = mat_ff[{k, j}];
      else if (op_ff == fmmp_pkg::OP_MULT_BASE)
         // base [[0,1],[1,1]] entries are 1 except (0,0); here mod m > 1 or 0
         mbv = ({k, j} == 2'b00) ? '0 : ((m_ff == MOD_BITS'(1)) ? '0 : MOD_BITS'(1));
      else mbv = (m_ff == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
      mc = k ? nxt_ff[step_ff[2:1]] : '0;
      if (op_ff == fmmp_pkg::OP_SUM_ROW) begin
         ma = mat_ff[{1'b0, k}];
         mc = k ? nxt_ff[0] : '0;
      end
   end

   fmmp_modmul #(.MOD_BITS(MOD_BITS)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (go_ff),
      .a     (ma),
      .b     (mbv),
      .c     (mc),
      .m     (m_ff),
      .done  (mm_done),
      .result(mm_res)
   );

   // Sequencing of the product terms.
   always_comb begin
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      go_in   = 1'b0;
      for (int e = 0; e < 4; e++) mat_in[e] = mat_ff[e];
      if (cmd.load) begin
         mat_in[0] = one_m;
         mat_in[1] = '0;
         mat_in[2] = '0;
         mat_in[3] = one_m;
      end else if (cmd.start) begin
         step_in = '0;
         busy_in = 1'b1;
         go_in   = 1'b1;
      end else if (busy_ff && mm_done) begin
         if (op_ff == fmmp_pkg::OP_SUM_ROW ? step_ff == 4'd1 : step_ff == 4'd7) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (op_ff != fmmp_pkg::OP_SUM_ROW) begin
               for (int e = 0; e < 3; e++) mat_in[e] = nxt_ff[e];
               mat_in[3] = mm_res;
            end
         end else begin
            step_in = step_ff + 4'd1;
            go_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         go_ff   <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         go_ff   <= go_in;
      end
      step_ff <= step_in;
      for (int e = 0; e < 4; e++) mat_ff[e] <= mat_in[e];
      if (busy_ff && mm_done) nxt_ff[step_ff[2:1]] <= mm_res;
      if (cmd.start) op_ff <= cmd.op;
      if (cmd.load) m_ff <= modulus;
   end

   assign status.busy = busy_ff | go_ff;
   assign status.done = done_ff;
   assign value       = nxt_ff[0];
endmodule

// ----- src/fmmp_ctrl.sv -----
// ----------------------------------------------------------------------------
// Fibonacci modulo matrix power: controller
// Walks the exponent bits from the top, issuing a square per bit and a
// multiply by the base where the bit is set, then the final row sum.
// ----------------------------------------------------------------------------
module fmmp_ctrl #(
   parameter int INDEX_BITS = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [INDEX_BITS-2:0]   n,
   input  logic                    mod_zero,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic                    use_const,
   output logic                    const_one,
   output fmmp_pkg::cmd_type       cmd,
   input  fmmp_pkg::status_type    status
);
   localparam int BW = $clog2(INDEX_BITS);

   fmmp_pkg::state_type state_ff, state_in;
   logic [INDEX_BITS-2:0] exp_ff, exp_in;
   logic [BW-1:0]         bit_ff, bit_in;
   logic                  cst_ff, cst_in, one_ff, one_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= fmmp_pkg::ST_IDLE;
      else       state_ff <= state_in;
      exp_ff <= exp_in;
      bit_ff <= bit_in;
      cst_ff <= cst_in;
      one_ff <= one_in;
   end

   // Next state and datapath commands.
   always_comb begin
      state_in  = state_ff;
      exp_in    = exp_ff;
      bit_in    = bit_ff;
      cst_in    = cst_ff;
      one_in    = one_ff;
      cmd       = '{load: 1'b0, start: 1'b0, op: fmmp_pkg::OP_SQUARE};
      in_ready  = 1'b0;
      out_valid = 1'b0;
      case (state_ff)
         fmmp_pkg::ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load = 1'b1;
               exp_in   = n - 1'b1;
               bit_in   = BW'(INDEX_BITS - 2);
               one_in   = (n == (INDEX_BITS-1)'(1));
               cst_in   = one_in || mod_zero || (n == '0);
               state_in = cst_in ? fmmp_pkg::ST_DONE : fmmp_pkg::ST_LOAD;
            end
         end
         fmmp_pkg::ST_LOAD: begin
            cmd.start = 1'b1;
            cmd.op    = fmmp_pkg::OP_SQUARE;
            state_in  = fmmp_pkg::ST_SQUARE;
         end
         fmmp_pkg::ST_SQUARE: begin
            if (status.done) begin
               if (exp_ff[bit_ff]) begin
                  cmd.start = 1'b1;
                  cmd.op    = fmmp_pkg::OP_MULT_BASE;
                  state_in  = fmmp_pkg::ST_MULT;
               end else if (bit_ff == '0) begin
                  cmd.start = 1'b1;
                  cmd.op    = fmmp_pkg::OP_SUM_ROW;
                  state_in  = fmmp_pkg::ST_FINAL;
               end else begin
                  bit_in    = bit_ff - 1'b1;
                  cmd.start = 1'b1;
                  state_in  = fmmp_pkg::ST_SQUARE;
               end
            end
         end
         fmmp_pkg::ST_MULT: begin
            if (status.done) begin
               cmd.start = 1'b1;
               if (bit_ff == '0) begin
                  cmd.op   = fmmp_pkg::OP_SUM_ROW;
                  state_in = fmmp_pkg::ST_FINAL;
               end else begin
                  bit_in   = bit_ff - 1'b1;
                  state_in = fmmp_pkg::ST_SQUARE;
               end
            end
         end
         fmmp_pkg::ST_FINAL: begin
            if (status.done) state_in = fmmp_pkg::ST_DONE;
         end
         fmmp_pkg::ST_DONE: begin
            out_valid = 1'b1;
            if (out_ready) state_in = fmmp_pkg::ST_IDLE;
         end
         default: state_in = fmmp_pkg::ST_IDLE;
      endcase
   end

   assign use_const = cst_ff;
   assign const_one = one_ff;
endmodule

// ----- src/fibonacci_mod_matrix_power.sv -----
// ----------------------------------------------------------------------------
// Fibonacci modulo matrix power
// Returns F(n) mod m by square-and-multiply of [[0,1],[1,1]].
//
//   Channel | Dir | Word contents (low bit first)
//   req_    | in  | n[INDEX_BITS-2:0], modulus[MOD_BITS-1:0], zero pad
//   rsp_    | out | value[MOD_BITS-2:0], zero pad
//
// One word at a time. Each matrix product runs its eight terms through the
// shared bit-serial multiply-add unit; a word takes one square per exponent
// bit plus one multiply by the base per set bit. n = 1, n = 0 or a zero
// modulus answer with a constant, without the datapath. Reset is
// synchronous; the result waits under rsp_tvalid until taken.
// ----------------------------------------------------------------------------
module fibonacci_mod_matrix_power #(
   parameter int INDEX_BITS = 64,
   parameter int MOD_BITS   = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // n (INDEX_BITS-1 bits), modulus (MOD_BITS bits), zero pad
   input  logic [((INDEX_BITS-1+MOD_BITS+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // value (MOD_BITS-1 bits), zero pad
   output logic [((MOD_BITS-1+7)/8)*8-1:0] rsp_tdata
);
   localparam int RW = ((MOD_BITS-1+7)/8)*8;

   fmmp_pkg::cmd_type    cmd;
   fmmp_pkg::status_type status;
   logic [INDEX_BITS-2:0] n;
   logic [MOD_BITS-1:0]   m_raw, m_sat, value;
   logic                  use_const, const_one;

   // Saturate the modulus to 2^(MOD_BITS-1).
   assign n     = req_tdata[INDEX_BITS-2:0];
   assign m_raw = req_tdata[INDEX_BITS-1 +: MOD_BITS];
   assign m_sat = m_raw[MOD_BITS-1] ? {1'b1, {(MOD_BITS-1){1'b0}}} : m_raw;

   fmmp_ctrl #(.INDEX_BITS(INDEX_BITS)) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .n        (n),
      .mod_zero (m_raw == '0),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .use_const(use_const),
      .const_one(const_one),
      .cmd      (cmd),
      .status   (status)
   );

   fmmp_datapath #(.MOD_BITS(MOD_BITS)) u_dp (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .modulus(m_sat),
      .status (status),
      .value  (value)
   );

   // Constant answers bypass the datapath.
   assign rsp_tdata = use_const ? RW'(const_one) : RW'(value[MOD_BITS-2:0]);
endmodule
